// ===== src/hall_six_step_commutator_core_assert.svh =====
// assertion macros for the hall commutator core
// expects i_clk and i_rst_n in the scope of use
`ifndef HALL_SIX_STEP_COMMUTATOR_CORE_ASSERT_SVH
`define HALL_SIX_STEP_COMMUTATOR_CORE_ASSERT_SVH

// property checked at every clock edge outside reset
`define HSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hsc_pkg.sv =====
// package for the hall six-step commutator: payload structs, constants, step table
// no dependencies
package hsc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;

    localparam logic [15:0] PERIOD_RESET = 16'd99;
    localparam logic [31:0] WINDOW_RESET = 32'd2000000;
    localparam logic [15:0] ROT_MAX      = 16'hffff;
    localparam logic [3:0]  CODE_SUM_ROT = 4'd10;
    localparam logic [17:0] SPEED_MAX    = 18'd163837;

    localparam logic [2:0] HALL_NONE     = 3'd0;
    localparam logic [2:0] HALL_ALL_HIGH = 3'd7;
    localparam logic [2:0] STEP_NONE     = 3'd0;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    typedef struct packed {
        logic       hall_a;
        logic       hall_b;
        logic       hall_c;
        logic [7:0] duty;
    } t_in_item;

    typedef struct packed {
        logic        high_a;
        logic        high_b;
        logic        high_c;
        logic        low_pin_a;
        logic        low_pin_b;
        logic        low_pin_c;
        logic        hall_valid;
        logic [17:0] speed_value;
        logic        window_done;
    } t_out_item;

    // high-side phase driven in each step
    function automatic logic [1:0] step_high_phase(input logic [2:0] step);
        logic [1:0] ph;
        unique case (step)
            3'd1:    ph = PH_A;
            3'd2:    ph = PH_B;
            3'd3:    ph = PH_A;
            3'd4:    ph = PH_C;
            3'd5:    ph = PH_C;
            3'd6:    ph = PH_B;
            default: ph = PH_A;
        endcase
        return ph;
    endfunction

    // conducting low-side phase in each step
    function automatic logic [1:0] step_low_phase(input logic [2:0] step);
        logic [1:0] ph;
        unique case (step)
            3'd1:    ph = PH_B;
            3'd2:    ph = PH_C;
            3'd3:    ph = PH_C;
            3'd4:    ph = PH_A;
            3'd5:    ph = PH_B;
            3'd6:    ph = PH_A;
            default: ph = PH_A;
        endcase
        return ph;
    endfunction

endpackage

// ===== src/hall_six_step_commutator_core.sv =====
// hall six-step commutator core: gate pattern, pwm compare and windowed speed meter
// depends on hsc_pkg and hall_six_step_commutator_core_assert.svh
//
//   channel   direction   handshake                       payload
//   in        input       i_in_valid / o_in_ready         i_in  (hsc_pkg::t_in_item)
//   out       output      o_out_valid / i_out_ready       o_out (hsc_pkg::t_out_item)
//   cfg       input       i_cfg_we, i_cfg_index           i_cfg_data
//
// one transaction per clock; result appears in the output register the cycle after
// acceptance, set by one pass of compare/add logic between state and output register
// o_in_ready drops only while a held result is not taken, so a stall costs no data
// synchronous active-low reset; registers but r_out reset, no result pending
`include "hall_six_step_commutator_core_assert.svh"

module hall_six_step_commutator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  hsc_pkg::t_in_item               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output hsc_pkg::t_out_item              o_out,
    input  logic                            i_cfg_we,
    input  logic [hsc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hsc_pkg::*;

    logic [15:0] r_pwm_period;
    logic [31:0] r_window_ticks;
    logic [15:0] r_pwm_cnt;
    logic [31:0] r_win_cnt;
    logic [2:0]  r_prev_code;
    logic [15:0] r_rot_cnt;
    logic [17:0] r_speed;
    logic [2:0]  r_step;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [15:0] n_pwm_cnt;
    logic [31:0] n_win_cnt;
    logic [15:0] n_rot_cnt;
    logic [17:0] n_speed;
    logic [2:0]  n_step;
    t_out_item   n_out;

    logic        in_fire;
    logic [2:0]  code;
    logic        code_ok;
    logic        pwm_on;
    logic [2:0]  highs;
    logic [2:0]  lows;
    logic [15:0] rot_upd;
    logic [18:0] speed_x5;
    logic [32:0] win_next;
    logic        win_end;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        code    = {i_in.hall_c, i_in.hall_b, i_in.hall_a};
        code_ok = (code != HALL_NONE) && (code != HALL_ALL_HIGH);
        pwm_on  = r_pwm_cnt < {8'd0, i_in.duty};
        n_step  = code_ok ? code : r_step;

        if (n_step != STEP_NONE) begin
            highs = pwm_on ? (3'b001 << step_high_phase(n_step)) : 3'b000;
            lows  = ~(3'b001 << step_low_phase(n_step));
        end else begin
            highs = 3'b000;
            lows  = 3'b000;
        end

        n_pwm_cnt = (r_pwm_cnt >= r_pwm_period) ? 16'd0 : r_pwm_cnt + 16'd1;

        // a change between codes summing to ten marks one rotation
        rot_upd = r_rot_cnt;
        if ((code != r_prev_code)
            && (({1'b0, r_prev_code} + {1'b0, code}) == CODE_SUM_ROT)
            && (r_rot_cnt != ROT_MAX)) begin
            rot_upd = r_rot_cnt + 16'd1;
        end

        // count * 60 / 24 == count * 5 / 2
        speed_x5 = {1'b0, rot_upd, 2'b00} + {3'b000, rot_upd};
        win_next = {1'b0, r_win_cnt} + 33'd1;
        win_end  = win_next >= {1'b0, r_window_ticks};

        if (win_end) begin
            n_speed   = speed_x5[18:1];
            n_rot_cnt = 16'd0;
            n_win_cnt = 32'd0;
        end else begin
            n_speed   = r_speed;
            n_rot_cnt = rot_upd;
            n_win_cnt = win_next[31:0];
        end

        n_out.high_a      = highs[PH_A];
        n_out.high_b      = highs[PH_B];
        n_out.high_c      = highs[PH_C];
        n_out.low_pin_a   = lows[PH_A];
        n_out.low_pin_b   = lows[PH_B];
        n_out.low_pin_c   = lows[PH_C];
        n_out.hall_valid  = code_ok;
        n_out.speed_value = n_speed;
        n_out.window_done = win_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period   <= PERIOD_RESET;
            r_window_ticks <= WINDOW_RESET;
            r_pwm_cnt      <= '0;
            r_win_cnt      <= '0;
            r_prev_code    <= HALL_NONE;
            r_rot_cnt      <= '0;
            r_speed        <= '0;
            r_step         <= STEP_NONE;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PWM_PERIOD:   r_pwm_period   <= i_cfg_data[15:0];
                    CFG_WINDOW_TICKS: r_window_ticks <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_pwm_cnt   <= n_pwm_cnt;
                r_win_cnt   <= n_win_cnt;
                r_prev_code <= code;
                r_rot_cnt   <= n_rot_cnt;
                r_speed     <= n_speed;
                r_step      <= n_step;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    `HSC_ASSERT(a_one_high, !r_out_valid || $onehot0({r_out.high_a, r_out.high_b, r_out.high_c}), "more than one high-side gate on")
    `HSC_ASSERT(a_high_has_low, !r_out_valid || !(r_out.high_a || r_out.high_b || r_out.high_c) || ($countones({r_out.low_pin_a, r_out.low_pin_b, r_out.low_pin_c}) == 2), "high side on without exactly one conducting low side")
    `HSC_ASSERT(a_speed_range, r_speed <= SPEED_MAX, "speed latch out of range")
    `HSC_ASSERT_NEXT(a_window_clear, in_fire && win_end, (r_rot_cnt == 16'd0) && (r_win_cnt == 32'd0), "window end did not clear counters")
    `HSC_ASSERT_NEXT(a_step_hold, in_fire && !code_ok, r_step == $past(r_step), "step changed on an invalid hall code")

endmodule
